// ===== design/slr_pkg.sv =====
// Shared package for the shuffled minimal-standard random generator.
// Holds the generator constants, controller state type and command/status structs.
// No dependencies.
package slr_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int WARMUP_EXTRA        = 7;

  localparam logic [14:0] LCG_MULT = 15'd16807;
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;

  localparam logic ACTION_DRAW = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_FOLD,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_DRAW_OUT
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic start_reseed;
    logic step_mul;
    logic seed_fold;
    logic draw_fold;
    logic draw_out;
  } dp_cmd_t;

  typedef struct packed {
    logic reseed_needed;
    logic count_done;
  } dp_status_t;

endpackage

// ===== design/shuffled_lcg_random.sv =====
// Load: the seed is written as the request is taken. Draw: multiply, then modular
// fold with the registered shuffle table read, then output, which waits on a
// stalled result; requests stall until idle. A draw that must reseed first runs
// warm-up steps until the counter from TABLE_DEPTH+WARMUP_EXTRA reaches zero.
// Reset clears the generator state and last output; table contents are undefined
// until the first warm-up fills them, so no clearing pass is run.
module shuffled_lcg_random #(
  parameter int TABLE_DEPTH = slr_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  logic               action,
  input  logic signed [31:0] seed_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [30:0]        random_value
);

  slr_pkg::dp_cmd_t    cmd;
  slr_pkg::dp_status_t status;

  slr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .action        (action),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .cmd           (cmd)
  );

  slr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .seed_value   (seed_value),
    .random_value (random_value)
  );

endmodule

// ===== design/slr_datapath.sv =====
// Datapath of the shuffled generator: state registers, multiply and modular fold,
// slot selection and the shuffle table memory. Depends on slr_pkg.
module slr_datapath #(
  parameter int TABLE_DEPTH = slr_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  slr_pkg::dp_cmd_t     cmd,
  output slr_pkg::dp_status_t  status,
  input  logic signed [31:0]   seed_value,
  output logic [30:0]          random_value
);

  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int START_COUNT = TABLE_DEPTH + slr_pkg::WARMUP_EXTRA;
  localparam int CNT_W       = $clog2(START_COUNT + 1);

  // Slot divisor and an exact reciprocal for any 31-bit dividend.
  localparam logic [63:0] SLOT_DIV =
    64'd1 + 64'(slr_pkg::LCG_MOD - 31'd1) / 64'(TABLE_DEPTH);
  localparam int          SLOT_L   = $clog2(SLOT_DIV);
  localparam int          SLOT_SH  = 31 + SLOT_L;
  localparam logic [63:0] RECIP_WIDE = ((64'd1 << SLOT_SH) + SLOT_DIV - 64'd1) / SLOT_DIV;
  localparam logic [31:0] SLOT_RECIP = RECIP_WIDE[31:0];

  logic [31:0]      lcg_state;
  logic [30:0]      last_output;
  logic [CNT_W-1:0] count;
  logic [46:0]      step_prod;
  logic [62:0]      slot_prod;
  logic [IDX_W-1:0] slot;
  logic [30:0]      table_rdata;
  logic [30:0]      mem [TABLE_DEPTH];

  logic [31:0]      fold_sum;
  logic [30:0]      fold_res;
  logic [31:0]      seed_norm;
  logic [62:0]      slot_quot;
  logic [IDX_W-1:0] slot_pick;

  // x mod (2^31-1) folds the high bits back onto the low bits; one subtract
  // finishes it since the sum stays below twice the modulus.
  assign fold_sum = {1'b0, step_prod[30:0]} + {16'd0, step_prod[46:31]};
  assign fold_res = (fold_sum >= {1'b0, slr_pkg::LCG_MOD}) ?
                    31'(fold_sum - {1'b0, slr_pkg::LCG_MOD}) : fold_sum[30:0];

  assign seed_norm = lcg_state[31] ? (32'd0 - lcg_state) : 32'd1;

  assign slot_quot = slot_prod >> SLOT_SH;
  assign slot_pick = (slot_quot >= 63'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) :
                     slot_quot[IDX_W-1:0];

  assign status.reseed_needed = (lcg_state == 32'd0) || lcg_state[31] ||
                                (last_output == 31'd0);
  assign status.count_done    = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state   <= '0;
      last_output <= '0;
    end else begin
      if (cmd.load_seed) begin
        lcg_state <= seed_value;
      end
      if (cmd.start_reseed) begin
        lcg_state <= seed_norm;
      end
      if (cmd.seed_fold || cmd.draw_fold) begin
        lcg_state <= {1'b0, fold_res};
      end
      if (cmd.seed_fold && status.count_done) begin
        last_output <= fold_res;
      end
      if (cmd.draw_out) begin
        last_output <= table_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_reseed) begin
      count <= CNT_W'(START_COUNT);
    end else if (cmd.seed_fold) begin
      count <= count - 1'b1;
    end
    if (cmd.step_mul) begin
      step_prod <= 47'(lcg_state) * 47'(slr_pkg::LCG_MULT);
      slot_prod <= 63'(last_output) * 63'(SLOT_RECIP);
    end
    if (cmd.draw_fold) begin
      slot <= slot_pick;
    end
    if (cmd.draw_out) begin
      random_value <= table_rdata;
    end
  end

  // Shuffle table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.seed_fold && (count < CNT_W'(TABLE_DEPTH))) begin
      mem[count[IDX_W-1:0]] <= fold_res;
    end else if (cmd.draw_out) begin
      mem[slot] <= lcg_state[30:0];
    end
    if (cmd.draw_fold) begin
      table_rdata <= mem[slot_pick];
    end
  end

  a_fold_reduced: assert property (@(posedge clk) disable iff (rst)
    (cmd.seed_fold || cmd.draw_fold) |=> (lcg_state < {1'b0, slr_pkg::LCG_MOD}))
    else $error("generator state not reduced below the modulus");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (cmd.seed_fold && !status.count_done) |=> (count == CNT_W'($past(count) - 1'b1)))
    else $error("warm-up counter skipped a step");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.draw_fold |=> (int'(slot) < TABLE_DEPTH))
    else $error("table slot out of range");

endmodule

// ===== design/slr_ctrl.sv =====
// Controller of the shuffled generator: sequences loads, warm-up and draws,
// and owns the result valid flag. Depends on slr_pkg.
module slr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  logic                action,
  output logic                result_valid,
  input  logic                result_stall,
  input  slr_pkg::dp_status_t status,
  output slr_pkg::dp_cmd_t    cmd
);

  slr_pkg::state_t state, state_next;
  logic            accept;

  assign request_stall = (state != slr_pkg::ST_IDLE);
  assign accept        = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      slr_pkg::ST_IDLE: begin
        if (accept && (action == slr_pkg::ACTION_DRAW)) begin
          state_next = status.reseed_needed ? slr_pkg::ST_SEED_MUL : slr_pkg::ST_DRAW_MUL;
        end
      end
      slr_pkg::ST_SEED_MUL:  state_next = slr_pkg::ST_SEED_FOLD;
      slr_pkg::ST_SEED_FOLD: begin
        state_next = status.count_done ? slr_pkg::ST_DRAW_MUL : slr_pkg::ST_SEED_MUL;
      end
      slr_pkg::ST_DRAW_MUL:  state_next = slr_pkg::ST_DRAW_FOLD;
      slr_pkg::ST_DRAW_FOLD: state_next = slr_pkg::ST_DRAW_OUT;
      slr_pkg::ST_DRAW_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = slr_pkg::ST_IDLE;
        end
      end
      default: state_next = slr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      slr_pkg::ST_IDLE: begin
        cmd.load_seed    = accept && (action == slr_pkg::ACTION_LOAD);
        cmd.start_reseed = accept && (action == slr_pkg::ACTION_DRAW) &&
                           status.reseed_needed;
      end
      slr_pkg::ST_SEED_MUL:  cmd.step_mul  = 1'b1;
      slr_pkg::ST_SEED_FOLD: cmd.seed_fold = 1'b1;
      slr_pkg::ST_DRAW_MUL:  cmd.step_mul  = 1'b1;
      slr_pkg::ST_DRAW_FOLD: cmd.draw_fold = 1'b1;
      slr_pkg::ST_DRAW_OUT:  cmd.draw_out  = !result_valid || !result_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.draw_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_reseed_path: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == slr_pkg::ACTION_DRAW) && status.reseed_needed)
    |=> (state == slr_pkg::ST_SEED_MUL))
    else $error("draw needing a reseed skipped the warm-up");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == slr_pkg::ST_DRAW_OUT))
    else $error("result appeared outside the output step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !cmd.draw_out)
    else $error("pending result overwritten");

endmodule
